>>> sv/ipc_rendezvous_engine_macros.svh
// Assertion macros for the IPC rendezvous engine.
// Used by the top level; no other dependencies.
`ifndef IPC_RENDEZVOUS_ENGINE_MACROS_SVH
`define IPC_RENDEZVOUS_ENGINE_MACROS_SVH
`ifndef ASSERT_OFF
`define IRE_ASSERT_IMP(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
    else $error("ire assertion failed");
`define IRE_ASSERT_NXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
    else $error("ire assertion failed");
`else
`define IRE_ASSERT_IMP(lbl, clk, rstn, a, b)
`define IRE_ASSERT_NXT(lbl, clk, rstn, a, b)
`endif
`endif

>>> sv/ire_pkg.sv
// Shared types and constants of the IPC rendezvous engine.
// Used by the controller, the datapath and the top level.
package ire_pkg;

  localparam int NUM_TASKS = 8;
  localparam int IDX_W     = $clog2(NUM_TASKS);
  localparam int CODE_W    = 4;
  localparam int WORD_W    = 32;
  localparam int CNT_W     = $clog2(NUM_TASKS + 1);

  localparam logic [CODE_W-1:0] IRQ_CODE   = CODE_W'(NUM_TASKS);
  localparam logic [CODE_W-1:0] ANY_CODE   = CODE_W'(NUM_TASKS + 1);
  localparam logic [CODE_W-1:0] NONE_CODE  = CODE_W'(NUM_TASKS + 2);
  localparam logic [CODE_W-1:0] EMPTY_CODE = CODE_W'(NUM_TASKS);

  typedef enum logic [1:0] {OP_SEND, OP_RECV, OP_IRQ, OP_BAD} op_t;

  typedef enum logic [1:0] {
    OUT_BLOCKED, OUT_DELIVERED, OUT_PENDED, OUT_INVALID
  } outcome_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EVAL, ST_CHAIN, ST_SEND_DEC, ST_APPEND, ST_UNLINK, ST_FINISH, ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    ACT_NONE, ACT_LOAD, ACT_IRQ_WAKE, ACT_IRQ_PEND, ACT_CHAIN_START, ACT_CHAIN_STEP,
    ACT_CHAIN_HIT, ACT_SEND_DELIVER, ACT_SEND_BLOCK, ACT_APPEND_STEP, ACT_APPEND_LINK,
    ACT_RECV_IRQ, ACT_RECV_BLOCK, ACT_UNLINK_START, ACT_UNLINK_STEP, ACT_UNLINK_HIT,
    ACT_RECV_FINISH, ACT_EMIT
  } act_t;

  typedef struct packed {
    act_t act;
    logic in_ready;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic bad_caller;
    logic caller_busy;
    logic peer_is_caller;
    logic peer_is_task;
    logic peer_too_high;
    logic irq_wake;
    logic irq_take;
    logic peer_recv_match;
    logic recv_src_found;
    logic peer_queue_empty;
    logic chain_stop;
    logic chain_hit;
    logic walk_done;
    logic append_end;
    logic unlink_end;
    logic unlink_hit;
    logic out_free;
  } status_t;

endpackage

>>> sv/ire_ctrl.sv
// Controller state machine of the IPC rendezvous engine.
// Depends on ire_pkg; drives the datapath through cmd_t and reads status_t.
module ire_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  ire_pkg::status_t status,
  output ire_pkg::cmd_t    cmd
);

  ire_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ire_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ire_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = ire_pkg::ST_EVAL;
      end
      ire_pkg::ST_EVAL: begin
        state_nxt = ire_pkg::ST_DONE;
        if (status.op == ire_pkg::OP_SEND && !status.bad_caller &&
            !status.caller_busy && !status.peer_is_caller && status.peer_is_task) begin
          state_nxt = ire_pkg::ST_CHAIN;
        end else if (status.op == ire_pkg::OP_RECV && !status.bad_caller &&
                     !status.caller_busy && !status.peer_is_caller &&
                     !status.peer_too_high && !status.irq_take &&
                     status.recv_src_found) begin
          state_nxt = ire_pkg::ST_UNLINK;
        end
      end
      ire_pkg::ST_CHAIN: begin
        if (status.walk_done || status.chain_stop || status.chain_hit)
          state_nxt = ire_pkg::ST_SEND_DEC;
      end
      ire_pkg::ST_SEND_DEC: begin
        if (status.peer_recv_match || status.peer_queue_empty) state_nxt = ire_pkg::ST_DONE;
        else state_nxt = ire_pkg::ST_APPEND;
      end
      ire_pkg::ST_APPEND: begin
        if (status.walk_done || status.append_end) state_nxt = ire_pkg::ST_DONE;
      end
      ire_pkg::ST_UNLINK: begin
        if (status.walk_done || status.unlink_end || status.unlink_hit)
          state_nxt = ire_pkg::ST_FINISH;
      end
      ire_pkg::ST_FINISH: state_nxt = ire_pkg::ST_DONE;
      ire_pkg::ST_DONE: begin
        if (status.out_free) state_nxt = ire_pkg::ST_IDLE;
      end
      default: state_nxt = ire_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.act      = ire_pkg::ACT_NONE;
    cmd.in_ready = 1'b0;
    case (state_r)
      ire_pkg::ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_tvalid) cmd.act = ire_pkg::ACT_LOAD;
      end
      ire_pkg::ST_EVAL: begin
        if (status.op == ire_pkg::OP_BAD || status.bad_caller) begin
          cmd.act = ire_pkg::ACT_NONE;
        end else if (status.op == ire_pkg::OP_IRQ) begin
          cmd.act = status.irq_wake ? ire_pkg::ACT_IRQ_WAKE : ire_pkg::ACT_IRQ_PEND;
        end else if (status.caller_busy || status.peer_is_caller) begin
          cmd.act = ire_pkg::ACT_NONE;
        end else if (status.op == ire_pkg::OP_SEND) begin
          if (status.peer_is_task) cmd.act = ire_pkg::ACT_CHAIN_START;
        end else if (!status.peer_too_high) begin
          if (status.irq_take) cmd.act = ire_pkg::ACT_RECV_IRQ;
          else if (status.recv_src_found) cmd.act = ire_pkg::ACT_UNLINK_START;
          else cmd.act = ire_pkg::ACT_RECV_BLOCK;
        end
      end
      ire_pkg::ST_CHAIN: begin
        if (status.walk_done || status.chain_stop) cmd.act = ire_pkg::ACT_NONE;
        else if (status.chain_hit) cmd.act = ire_pkg::ACT_CHAIN_HIT;
        else cmd.act = ire_pkg::ACT_CHAIN_STEP;
      end
      ire_pkg::ST_SEND_DEC: begin
        cmd.act = status.peer_recv_match ? ire_pkg::ACT_SEND_DELIVER
                                         : ire_pkg::ACT_SEND_BLOCK;
      end
      ire_pkg::ST_APPEND: begin
        if (status.walk_done || status.append_end) cmd.act = ire_pkg::ACT_APPEND_LINK;
        else cmd.act = ire_pkg::ACT_APPEND_STEP;
      end
      ire_pkg::ST_UNLINK: begin
        if (status.walk_done || status.unlink_end) cmd.act = ire_pkg::ACT_NONE;
        else if (status.unlink_hit) cmd.act = ire_pkg::ACT_UNLINK_HIT;
        else cmd.act = ire_pkg::ACT_UNLINK_STEP;
      end
      ire_pkg::ST_FINISH: cmd.act = ire_pkg::ACT_RECV_FINISH;
      ire_pkg::ST_DONE: begin
        if (status.out_free) cmd.act = ire_pkg::ACT_EMIT;
      end
      default: cmd.act = ire_pkg::ACT_NONE;
    endcase
  end

endmodule

>>> sv/ire_datapath.sv
// Datapath of the IPC rendezvous engine: per-task state, queue walks,
// message store and the output register. Depends on ire_pkg.
module ire_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [39:0]      in_tdata,
  input  logic [1:0]       in_tuser,
  input  logic             out_tready,
  output logic             out_tvalid,
  output logic [47:0]      out_tdata,
  output logic [1:0]       out_tuser,
  input  ire_pkg::cmd_t    cmd,
  output ire_pkg::status_t status
);

  localparam int N  = ire_pkg::NUM_TASKS;
  localparam int IW = ire_pkg::IDX_W;
  localparam int CW = ire_pkg::CODE_W;
  localparam int WW = ire_pkg::WORD_W;

  // Captured item.
  ire_pkg::op_t   op_r;
  logic [IW-1:0]  caller_r;
  logic [CW-1:0]  peer_r;
  logic [WW-1:0]  word_r;

  // Per-task state; bit 0 of a flag pair marks sending, bit 1 receiving.
  logic [1:0]     flags_r  [N];
  logic [IW-1:0]  target_r [N];
  logic [CW-1:0]  wait_r   [N];
  logic           pend_r   [N];
  logic [CW-1:0]  head_r   [N];
  logic [CW-1:0]  next_r   [N];
  logic [WW-1:0]  held_mem [N];
  logic [WW-1:0]  held_rd_r;

  // Walk pointers.
  logic [CW-1:0]            ptr_r;
  logic [CW-1:0]            prev_r;
  logic [ire_pkg::CNT_W-1:0] cnt_r;
  logic [IW-1:0]            from_r;

  // Result under construction and the output register.
  ire_pkg::outcome_t res_outcome_r;
  logic [IW-1:0]     res_recv_r;
  logic [CW-1:0]     res_src_r;
  logic [WW-1:0]     res_word_r;
  logic              res_wv_r;
  logic [IW-1:0]     res_wt_r;
  logic              res_dl_r;
  logic              out_valid_r;
  logic [47:0]       out_data_r;
  logic [1:0]        out_user_r;

  logic [IW-1:0] pi;
  logic [IW-1:0] pt;
  logic [IW-1:0] from_sel;
  logic [CW-1:0] caller_code;

  assign pi          = peer_r[IW-1:0];
  assign pt          = ptr_r[IW-1:0];
  assign caller_code = CW'(caller_r);
  assign from_sel    = (peer_r == ire_pkg::ANY_CODE) ? head_r[caller_r][IW-1:0] : pi;

  always_comb begin
    status.op              = op_r;
    status.bad_caller      = {1'b0, caller_r} >= (IW + 1)'(N);
    status.caller_busy     = flags_r[caller_r] != 2'b00;
    status.peer_is_caller  = peer_r == caller_code;
    status.peer_is_task    = peer_r < ire_pkg::EMPTY_CODE;
    status.peer_too_high   = peer_r > ire_pkg::ANY_CODE;
    status.irq_wake        = flags_r[caller_r][1] &&
                             (wait_r[caller_r] == ire_pkg::IRQ_CODE ||
                              wait_r[caller_r] == ire_pkg::ANY_CODE);
    status.irq_take        = pend_r[caller_r] &&
                             (peer_r == ire_pkg::ANY_CODE || peer_r == ire_pkg::IRQ_CODE);
    status.peer_recv_match = flags_r[pi][1] &&
                             (wait_r[pi] == caller_code || wait_r[pi] == ire_pkg::ANY_CODE);
    status.recv_src_found  = (peer_r == ire_pkg::ANY_CODE &&
                              head_r[caller_r] < ire_pkg::EMPTY_CODE) ||
                             (peer_r < ire_pkg::EMPTY_CODE && flags_r[pi][0] &&
                              target_r[pi] == caller_r);
    status.peer_queue_empty = head_r[pi] >= ire_pkg::EMPTY_CODE;
    status.chain_stop      = !flags_r[pt][0];
    status.chain_hit       = target_r[pt] == caller_r;
    status.walk_done       = cnt_r == ire_pkg::CNT_W'(N);
    status.append_end      = next_r[pt] >= ire_pkg::EMPTY_CODE;
    status.unlink_end      = ptr_r >= ire_pkg::EMPTY_CODE;
    status.unlink_hit      = ptr_r == CW'(from_r);
    status.out_free        = !out_valid_r || out_tready;
  end

  // Message store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.act == ire_pkg::ACT_SEND_BLOCK) held_mem[caller_r] <= word_r;
    if (cmd.act == ire_pkg::ACT_UNLINK_START) held_rd_r <= held_mem[from_sel];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) begin
        flags_r[i]  <= 2'b00;
        target_r[i] <= '0;
        wait_r[i]   <= ire_pkg::NONE_CODE;
        pend_r[i]   <= 1'b0;
        head_r[i]   <= ire_pkg::EMPTY_CODE;
        next_r[i]   <= ire_pkg::EMPTY_CODE;
      end
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.act == ire_pkg::ACT_EMIT) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      case (cmd.act)
        ire_pkg::ACT_LOAD: begin
          op_r          <= ire_pkg::op_t'(in_tuser);
          caller_r      <= in_tdata[2:0];
          peer_r        <= in_tdata[6:3];
          word_r        <= in_tdata[38:7];
          res_outcome_r <= ire_pkg::OUT_INVALID;
          res_recv_r    <= '0;
          res_src_r     <= '0;
          res_word_r    <= '0;
          res_wv_r      <= 1'b0;
          res_wt_r      <= '0;
          res_dl_r      <= 1'b0;
        end
        ire_pkg::ACT_IRQ_WAKE: begin
          flags_r[caller_r][1] <= 1'b0;
          wait_r[caller_r]     <= ire_pkg::NONE_CODE;
          pend_r[caller_r]     <= 1'b0;
          res_outcome_r        <= ire_pkg::OUT_DELIVERED;
          res_recv_r           <= caller_r;
          res_src_r            <= ire_pkg::IRQ_CODE;
          res_wv_r             <= 1'b1;
          res_wt_r             <= caller_r;
        end
        ire_pkg::ACT_IRQ_PEND: begin
          pend_r[caller_r] <= 1'b1;
          res_outcome_r    <= ire_pkg::OUT_PENDED;
        end
        ire_pkg::ACT_CHAIN_START: begin
          ptr_r <= peer_r;
          cnt_r <= '0;
        end
        ire_pkg::ACT_CHAIN_STEP: begin
          ptr_r <= CW'(target_r[pt]);
          cnt_r <= cnt_r + 1'b1;
        end
        ire_pkg::ACT_CHAIN_HIT: res_dl_r <= 1'b1;
        ire_pkg::ACT_SEND_DELIVER: begin
          flags_r[pi][1] <= 1'b0;
          wait_r[pi]     <= ire_pkg::NONE_CODE;
          res_outcome_r  <= ire_pkg::OUT_DELIVERED;
          res_recv_r     <= pi;
          res_src_r      <= caller_code;
          res_word_r     <= word_r;
          res_wv_r       <= 1'b1;
          res_wt_r       <= pi;
        end
        ire_pkg::ACT_SEND_BLOCK: begin
          flags_r[caller_r][0] <= 1'b1;
          target_r[caller_r]   <= pi;
          next_r[caller_r]     <= ire_pkg::EMPTY_CODE;
          res_outcome_r        <= ire_pkg::OUT_BLOCKED;
          // An empty queue takes the caller as its head; otherwise walk to the tail.
          if (head_r[pi] >= ire_pkg::EMPTY_CODE) head_r[pi] <= caller_code;
          ptr_r <= head_r[pi];
          cnt_r <= '0;
        end
        ire_pkg::ACT_APPEND_STEP: begin
          ptr_r <= next_r[pt];
          cnt_r <= cnt_r + 1'b1;
        end
        ire_pkg::ACT_APPEND_LINK: next_r[pt] <= caller_code;
        ire_pkg::ACT_RECV_IRQ: begin
          pend_r[caller_r] <= 1'b0;
          res_outcome_r    <= ire_pkg::OUT_DELIVERED;
          res_recv_r       <= caller_r;
          res_src_r        <= ire_pkg::IRQ_CODE;
        end
        ire_pkg::ACT_RECV_BLOCK: begin
          flags_r[caller_r][1] <= 1'b1;
          wait_r[caller_r]     <= peer_r;
          res_outcome_r        <= ire_pkg::OUT_BLOCKED;
        end
        ire_pkg::ACT_UNLINK_START: begin
          from_r <= from_sel;
          ptr_r  <= head_r[caller_r];
          prev_r <= ire_pkg::EMPTY_CODE;
          cnt_r  <= '0;
        end
        ire_pkg::ACT_UNLINK_STEP: begin
          prev_r <= ptr_r;
          ptr_r  <= next_r[pt];
          cnt_r  <= cnt_r + 1'b1;
        end
        ire_pkg::ACT_UNLINK_HIT: begin
          if (prev_r >= ire_pkg::EMPTY_CODE) head_r[caller_r] <= next_r[pt];
          else next_r[prev_r[IW-1:0]] <= next_r[pt];
        end
        ire_pkg::ACT_RECV_FINISH: begin
          next_r[from_r]     <= ire_pkg::EMPTY_CODE;
          flags_r[from_r][0] <= 1'b0;
          target_r[from_r]   <= '0;
          res_outcome_r      <= ire_pkg::OUT_DELIVERED;
          res_recv_r         <= caller_r;
          res_src_r          <= CW'(from_r);
          res_word_r         <= held_rd_r;
          res_wv_r           <= 1'b1;
          res_wt_r           <= from_r;
        end
        ire_pkg::ACT_EMIT: begin
          out_user_r  <= res_outcome_r;
          out_data_r  <= {4'b0000, res_dl_r, res_wt_r, res_wv_r, res_word_r,
                          res_src_r, res_recv_r};
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

>>> sv/ipc_rendezvous_engine.sv
// Top level of the IPC rendezvous engine: controller plus datapath.
// Depends on ire_pkg, ire_ctrl, ire_datapath and the assertion macro header.
//
// Usage: each item on the in_ channel is a send, receive or interrupt
// notice from a task; each item yields exactly one result item on out_.
// An item is taken only while the engine is idle. After acceptance the
// item is decoded, then runs the deadlock chain walk and the sender-queue
// walk where its operation needs them, each stepping one link per cycle
// through the per-task state, and then its result is loaded into the
// output register. The next item is accepted the cycle after its result is
// loaded, even while that result still waits in the output register. If
// the receiver stalls, the finished result holds in out_ and the engine
// waits for space before loading the next one. Reset clears all task
// flags, queues and pending interrupts at once; stored message words are
// not cleared and are only read after being written by a send.
`include "ipc_rendezvous_engine_macros.svh"
module ipc_rendezvous_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // caller_task[2:0], peer[6:3], message_word[38:7], pad
  input  logic [1:0]  in_tuser,   // op[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // receiver_task[2:0], message_source[6:3],
                                  // delivered_word[38:7], woken_valid[39],
                                  // woken_task[42:40], deadlock_found[43], pad
  output logic [1:0]  out_tuser   // outcome[1:0]
);

  ire_pkg::cmd_t    cmd;
  ire_pkg::status_t status;

  ire_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .status   (status),
    .cmd      (cmd)
  );

  ire_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tready(out_tready),
    .out_tvalid(out_tvalid),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cmd       (cmd),
    .status    (status)
  );

  assign in_tready = cmd.in_ready;

  `IRE_ASSERT_NXT(a_one_item_at_a_time, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `IRE_ASSERT_NXT(a_emit_shows_result, clk, rst_n, cmd.act == ire_pkg::ACT_EMIT, out_tvalid)
  `IRE_ASSERT_IMP(a_wake_only_on_delivery, clk, rst_n, out_tvalid && out_tdata[39], out_tuser == ire_pkg::OUT_DELIVERED)

endmodule

>>> sim/tb_ipc_rendezvous_engine.sv
// Testbench for the IPC rendezvous engine: directed table plus random traffic.
// Results are checked against a behavioral predictor or against typed expected values; depends on ire_pkg and the RTL.
`timescale 1ns / 1ps
module tb_ipc_rendezvous_engine;

  typedef struct packed {
    ire_pkg::outcome_t outcome;
    logic [2:0]  receiver;
    logic [3:0]  source;
    logic [31:0] word;
    logic        woken_valid;
    logic [2:0]  woken;
    logic        deadlock;
  } rdv_result_t;

  typedef struct {
    ire_pkg::op_t op;
    logic [2:0]  caller;
    logic [3:0]  peer;
    logic [31:0] word;
    logic        has_exp;
    rdv_result_t exp;
  } call_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;

  ipc_rendezvous_engine dut (.*);

  always #5 clk = ~clk;

  // Predictor copy of the per-task state.
  logic [1:0]  flags_q [ire_pkg::NUM_TASKS];
  logic [2:0]  target_q [ire_pkg::NUM_TASKS];
  logic [3:0]  waitsrc_q [ire_pkg::NUM_TASKS];
  logic        irq_pend_q [ire_pkg::NUM_TASKS];
  logic [31:0] held_q [ire_pkg::NUM_TASKS];
  logic [3:0]  qhead_q [ire_pkg::NUM_TASKS];
  logic [3:0]  qnext_q [ire_pkg::NUM_TASKS];

  rdv_result_t pending_results[$];
  int          errors = 0;
  bit          stim_done = 1'b0;

  function automatic void clear_tasks();
    for (int i = 0; i < ire_pkg::NUM_TASKS; i++) begin
      flags_q[i] = 2'b00;
      target_q[i] = '0;
      waitsrc_q[i] = ire_pkg::NONE_CODE;
      irq_pend_q[i] = 1'b0;
      held_q[i] = '0;
      qhead_q[i] = ire_pkg::EMPTY_CODE;
      qnext_q[i] = ire_pkg::EMPTY_CODE;
    end
  endfunction

  function automatic bit sender_chain_hits(int from, int to);
    int t;
    t = from;
    for (int i = 0; i < ire_pkg::NUM_TASKS; i++) begin
      if (t >= ire_pkg::NUM_TASKS || !flags_q[t][0]) return 1'b0;
      if (target_q[t] == to) return 1'b1;
      t = target_q[t];
    end
    return 1'b0;
  endfunction

  function automatic void enqueue_sender(int dst, int s);
    int cur;
    cur = qhead_q[dst];
    qnext_q[s] = ire_pkg::EMPTY_CODE;
    if (cur >= ire_pkg::NUM_TASKS) begin
      qhead_q[dst] = 4'(s);
      return;
    end
    for (int i = 0; i < ire_pkg::NUM_TASKS; i++) begin
      if (qnext_q[cur] >= ire_pkg::NUM_TASKS) break;
      cur = qnext_q[cur];
    end
    qnext_q[cur] = 4'(s);
  endfunction

  function automatic void dequeue_sender(int owner, int s);
    int prev, cur;
    prev = ire_pkg::EMPTY_CODE;
    cur = qhead_q[owner];
    for (int i = 0; i < ire_pkg::NUM_TASKS && cur < ire_pkg::NUM_TASKS; i++) begin
      if (cur == s) begin
        if (prev >= ire_pkg::NUM_TASKS) qhead_q[owner] = qnext_q[cur];
        else qnext_q[prev] = qnext_q[cur];
        break;
      end
      prev = cur;
      cur = qnext_q[cur];
    end
    qnext_q[s] = ire_pkg::EMPTY_CODE;
  endfunction

  function automatic rdv_result_t predict_rendezvous(ire_pkg::op_t op, int c, int p,
                                                     logic [31:0] w);
    rdv_result_t r;
    int from;
    r = '0;
    r.outcome = ire_pkg::OUT_INVALID;
    if (op == ire_pkg::OP_BAD) begin
      r.outcome = ire_pkg::OUT_INVALID;
    end else if (op == ire_pkg::OP_IRQ) begin
      if (flags_q[c][1] && (waitsrc_q[c] == ire_pkg::IRQ_CODE ||
                            waitsrc_q[c] == ire_pkg::ANY_CODE)) begin
        flags_q[c][1] = 1'b0;
        waitsrc_q[c] = ire_pkg::NONE_CODE;
        irq_pend_q[c] = 1'b0;
        r.outcome = ire_pkg::OUT_DELIVERED;
        r.receiver = 3'(c);
        r.source = ire_pkg::IRQ_CODE;
        r.woken_valid = 1'b1;
        r.woken = 3'(c);
      end else begin
        irq_pend_q[c] = 1'b1;
        r.outcome = ire_pkg::OUT_PENDED;
      end
    end else if (flags_q[c] != 0 || p == c) begin
      r.outcome = ire_pkg::OUT_INVALID;
    end else if (op == ire_pkg::OP_SEND) begin
      if (p < ire_pkg::NUM_TASKS) begin
        r.deadlock = sender_chain_hits(p, c);
        if (flags_q[p][1] && (waitsrc_q[p] == c || waitsrc_q[p] == ire_pkg::ANY_CODE)) begin
          flags_q[p][1] = 1'b0;
          waitsrc_q[p] = ire_pkg::NONE_CODE;
          r.outcome = ire_pkg::OUT_DELIVERED;
          r.receiver = 3'(p);
          r.source = 4'(c);
          r.word = w;
          r.woken_valid = 1'b1;
          r.woken = 3'(p);
        end else begin
          flags_q[c][0] = 1'b1;
          target_q[c] = 3'(p);
          held_q[c] = w;
          enqueue_sender(p, c);
          r.outcome = ire_pkg::OUT_BLOCKED;
        end
      end
    end else if (p <= ire_pkg::ANY_CODE) begin
      from = ire_pkg::EMPTY_CODE;
      if (irq_pend_q[c] && (p == ire_pkg::ANY_CODE || p == ire_pkg::IRQ_CODE)) begin
        irq_pend_q[c] = 1'b0;
        r.outcome = ire_pkg::OUT_DELIVERED;
        r.receiver = 3'(c);
        r.source = ire_pkg::IRQ_CODE;
      end else begin
        if (p == ire_pkg::ANY_CODE) begin
          if (qhead_q[c] < ire_pkg::NUM_TASKS) from = qhead_q[c];
        end else if (p < ire_pkg::NUM_TASKS) begin
          if (flags_q[p][0] && target_q[p] == c) from = p;
        end
        if (from < ire_pkg::NUM_TASKS) begin
          dequeue_sender(c, from);
          r.word = held_q[from];
          flags_q[from][0] = 1'b0;
          target_q[from] = '0;
          r.outcome = ire_pkg::OUT_DELIVERED;
          r.receiver = 3'(c);
          r.source = 4'(from);
          r.woken_valid = 1'b1;
          r.woken = 3'(from);
        end else begin
          flags_q[c][1] = 1'b1;
          waitsrc_q[c] = 4'(p);
          r.outcome = ire_pkg::OUT_BLOCKED;
        end
      end
    end
    return r;
  endfunction

  function automatic rdv_result_t invalid_result();
    rdv_result_t r;
    r = '0;
    r.outcome = ire_pkg::OUT_INVALID;
    return r;
  endfunction

  task automatic issue_call(ire_pkg::op_t op, logic [2:0] c, logic [3:0] p, logic [31:0] w,
                            logic has_exp, rdv_result_t exp);
    rdv_result_t r;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {1'b0, w, p, c};
    do @(posedge clk); while (!in_tready);
    // The predictor always runs to keep its state; typed rows are checked as typed.
    r = predict_rendezvous(op, c, p, w);
    if (has_exp) pending_results.push_back(exp);
    else pending_results.push_back(r);
  endtask

  // Sender bursts: after each item, maybe drop valid for a random gap.
  int burst_left = 0;
  task automatic sender_gap();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 12);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Receiver stall pattern: random-length runs, each ready or stalled at random.
  int rdy_run = 0;
  always @(posedge clk) begin
    if (rdy_run == 0) begin
      rdy_run <= $urandom_range(1, 15);
      out_tready <= ($urandom_range(0, 2) != 0);
    end else begin
      rdy_run <= rdy_run - 1;
    end
  end

  always @(posedge clk) begin
    rdv_result_t exp, got;
    if (rst_n && out_tvalid && out_tready) begin
      got = {ire_pkg::outcome_t'(out_tuser), out_tdata[2:0], out_tdata[6:3],
             out_tdata[38:7], out_tdata[39], out_tdata[42:40], out_tdata[43]};
      if (pending_results.size() == 0) begin
        $error("result item with no call outstanding");
        errors++;
      end else begin
        exp = pending_results.pop_front();
        if (got.outcome !== exp.outcome) begin
          $error("outcome: expected %0d, got %0d", exp.outcome, got.outcome); errors++;
        end
        if (got.receiver !== exp.receiver) begin
          $error("receiver_task: expected %0d, got %0d", exp.receiver, got.receiver);
          errors++;
        end
        if (got.source !== exp.source) begin
          $error("message_source: expected %0d, got %0d", exp.source, got.source);
          errors++;
        end
        if (got.word !== exp.word) begin
          $error("delivered_word: expected %h, got %h", exp.word, got.word); errors++;
        end
        if (got.woken_valid !== exp.woken_valid) begin
          $error("woken_valid: expected %0d, got %0d", exp.woken_valid, got.woken_valid);
          errors++;
        end
        if (got.woken !== exp.woken) begin
          $error("woken_task: expected %0d, got %0d", exp.woken, got.woken); errors++;
        end
        if (got.deadlock !== exp.deadlock) begin
          $error("deadlock_found: expected %0d, got %0d", exp.deadlock, got.deadlock);
          errors++;
        end
      end
    end
  end

  call_row_t directed[$];

  task automatic add_row(ire_pkg::op_t op, int c, int p, logic [31:0] w, bit chk,
                         rdv_result_t e);
    call_row_t row;
    row.op = op; row.caller = 3'(c); row.peer = 4'(p); row.word = w;
    row.has_exp = chk; row.exp = e;
    directed.push_back(row);
  endtask

  initial begin
    rdv_result_t e, none;
    int kind, c, p;
    logic [31:0] w;
    none = '0;
    clear_tasks();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Invalid op and bad peers are plain rejections.
    add_row(ire_pkg::OP_BAD, 0, 0, 32'hFFFF_FFFF, 1, invalid_result());
    add_row(ire_pkg::OP_SEND, 3, 3, 32'h1, 1, invalid_result());
    add_row(ire_pkg::OP_SEND, 3, ire_pkg::IRQ_CODE, 32'h1, 1, invalid_result());
    add_row(ire_pkg::OP_SEND, 3, 15, 32'h1, 1, invalid_result());
    add_row(ire_pkg::OP_RECV, 4, 4, '0, 1, invalid_result());
    add_row(ire_pkg::OP_RECV, 4, ire_pkg::NONE_CODE, '0, 1, invalid_result());
    add_row(ire_pkg::OP_RECV, 4, 15, '0, 1, invalid_result());
    // Interrupt pended, then taken by a receive from the interrupt source.
    e = '0; e.outcome = ire_pkg::OUT_PENDED;
    add_row(ire_pkg::OP_IRQ, 7, 15, 32'hFFFF_FFFF, 1, e);
    e = '0; e.outcome = ire_pkg::OUT_DELIVERED; e.receiver = 7;
    e.source = ire_pkg::IRQ_CODE;
    add_row(ire_pkg::OP_RECV, 7, ire_pkg::IRQ_CODE, '0, 1, e);
    // Receive from interrupt with none pending blocks, notice wakes it.
    e = '0; e.outcome = ire_pkg::OUT_BLOCKED;
    add_row(ire_pkg::OP_RECV, 0, ire_pkg::IRQ_CODE, '0, 1, e);
    add_row(ire_pkg::OP_SEND, 0, 1, '0, 1, invalid_result());
    add_row(ire_pkg::OP_IRQ, 0, 0, '0, 0, none);
    // Queue of senders on task 2, deadlock cycle, extremes of the word.
    add_row(ire_pkg::OP_SEND, 1, 2, 32'hFFFF_FFFF, 0, none);
    add_row(ire_pkg::OP_SEND, 5, 2, 32'h0000_0000, 0, none);
    add_row(ire_pkg::OP_SEND, 2, 1, 32'hA5A5_5A5A, 0, none);
    add_row(ire_pkg::OP_SEND, 6, 2, 32'h8000_0001, 0, none);
    add_row(ire_pkg::OP_RECV, 2, ire_pkg::ANY_CODE, '0, 0, none);
    add_row(ire_pkg::OP_RECV, 2, 6, '0, 0, none);
    add_row(ire_pkg::OP_RECV, 2, ire_pkg::ANY_CODE, '0, 0, none);
    add_row(ire_pkg::OP_RECV, 1, ire_pkg::ANY_CODE, '0, 0, none);
    add_row(ire_pkg::OP_RECV, 3, ire_pkg::ANY_CODE, '0, 0, none);
    add_row(ire_pkg::OP_SEND, 4, 3, 32'h7FFF_FFFF, 0, none);
    add_row(ire_pkg::OP_RECV, 5, ire_pkg::ANY_CODE, '0, 0, none);
    add_row(ire_pkg::OP_IRQ, 5, 0, '0, 0, none);

    foreach (directed[i]) begin
      issue_call(directed[i].op, directed[i].caller, directed[i].peer, directed[i].word,
                 directed[i].has_exp, directed[i].exp);
      sender_gap();
    end

    // Mostly well-formed sends and receives among a few tasks, with some noise.
    for (int n = 0; n < 1650; n++) begin
      kind = $urandom_range(0, 99);
      c = $urandom_range(0, (n % 300 < 150) ? 3 : 7);
      w = $urandom();
      if (kind < 40) begin
        p = $urandom_range(0, 7);
        if (p == c && kind > 2) p = (p + 1) % ire_pkg::NUM_TASKS;
        issue_call(ire_pkg::OP_SEND, 3'(c), 4'(p), w, 0, none);
      end else if (kind < 82) begin
        p = (kind < 60) ? ire_pkg::ANY_CODE :
            (kind < 66 ? ire_pkg::IRQ_CODE : $urandom_range(0, 15));
        issue_call(ire_pkg::OP_RECV, 3'(c), 4'(p), w, 0, none);
      end else if (kind < 94) begin
        issue_call(ire_pkg::OP_IRQ, 3'(c), 4'($urandom_range(0, 15)), w, 0, none);
      end else begin
        issue_call(ire_pkg::OP_BAD, 3'(c), 4'($urandom_range(0, 15)), w, 0, none);
      end
      sender_gap();
    end
    in_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * ire_pkg::NUM_TASKS + 10) @(posedge clk);
    if (errors == 0) begin
      $display("tb_ipc_rendezvous_engine: PASS");
    end else begin
      $display("tb_ipc_rendezvous_engine: FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_ipc_rendezvous_engine: FAIL");
    $finish;
  end

endmodule
